// ===== hw/rtl/segment_tree_range_sum_top_macros.svh =====
`ifndef SEGMENT_TREE_RANGE_SUM_TOP_MACROS_SVH
`define SEGMENT_TREE_RANGE_SUM_TOP_MACROS_SVH

// Assertion that the consequent holds in the same cycle as the antecedent.
`define ST_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Assertion that the consequent holds in the cycle after the antecedent.
`define ST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/stsum_pkg.sv =====
`timescale 1ns / 1ps

package stsum_pkg;

   localparam int MAX_ELEMENTS_DEFAULT = 1024;

   localparam int INDEX_W = 10;
   localparam int VALUE_W = 32;
   localparam int SIZE_W  = 11;

   localparam logic [SIZE_W-1:0] ARRAY_SIZE_RESET = 11'd1024;

   localparam logic OP_SET   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

endpackage

// ===== hw/rtl/stsum_ifs.sv =====
`timescale 1ns / 1ps

interface stsum_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  operation;
   logic        [stsum_pkg::INDEX_W-1:0]  update_index;
   logic signed [stsum_pkg::VALUE_W-1:0]  new_value;
   logic        [stsum_pkg::INDEX_W-1:0]  range_low;
   logic        [stsum_pkg::INDEX_W-1:0]  range_high;

   modport source (output valid, operation, update_index, new_value, range_low, range_high,
                   input ready);
   modport sink   (input valid, operation, update_index, new_value, range_low, range_high,
                   output ready);
endinterface

interface stsum_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [stsum_pkg::VALUE_W-1:0]  range_sum;

   modport source (output valid, range_sum, input ready);
   modport sink   (input valid, range_sum, output ready);
endinterface

// ===== hw/rtl/stsum_node_store.sv =====
`timescale 1ns / 1ps

module stsum_node_store #(
   parameter int NODES = 2 * stsum_pkg::MAX_ELEMENTS_DEFAULT,
   parameter int AW    = $clog2(NODES)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [AW-1:0]                  wr_addr,
   input  logic [stsum_pkg::VALUE_W-1:0]  wr_data,
   input  logic [AW-1:0]                  rd_addr,
   output logic [stsum_pkg::VALUE_W-1:0]  rd_data,
   output logic                           clear_busy
);

   logic [stsum_pkg::VALUE_W-1:0] mem [NODES];
   logic [stsum_pkg::VALUE_W-1:0] rd_data_ff;
   logic [AW-1:0]                 clr_ff;
   logic [AW-1:0]                 clr_in;
   logic                          busy_ff;
   logic                          busy_in;
   logic                          mem_we;
   logic [AW-1:0]                 mem_wa;
   logic [stsum_pkg::VALUE_W-1:0] mem_wd;

   // After reset every node is swept to zero, one per cycle.
   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == AW'(NODES - 1)) begin
            busy_in = 1'b0;
         end
      end
      mem_we = busy_ff | wr_en;
      mem_wa = busy_ff ? clr_ff : wr_addr;
      mem_wd = busy_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = busy_ff;

endmodule

// ===== hw/rtl/segment_tree_range_sum_top.sv =====
`timescale 1ns / 1ps
// Update: an in-range update writes its leaf when accepted; per level S_UREAD reads the
// sibling and S_UADD writes the parent sum up to the root; other updates are ignored.
// Query: per tree level walked, S_QL and S_QR add the bound nodes; S_OUT then delivers.
// One transaction is in work at a time; the next is accepted at the end of the first idle
// cycle, while a finished result may still wait in the output register.
// Reset is synchronous; afterwards a clearing pass zeroes the tree before any request is taken.

`include "segment_tree_range_sum_top_macros.svh"

module segment_tree_range_sum_top #(
   parameter int MAX_ELEMENTS = stsum_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   stsum_req_if.sink                     req_bus,
   stsum_rsp_if.source                   rsp_bus,
   input  logic                          csr_write_enable,
   input  logic [stsum_pkg::SIZE_W-1:0]  csr_write_data
);

   localparam int NODES = 2 * MAX_ELEMENTS;
   localparam int AW    = $clog2(NODES);
   localparam int RW    = $clog2(NODES + 1);
   localparam int VW    = stsum_pkg::VALUE_W;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_UREAD = 6'b000010,
      S_UADD  = 6'b000100,
      S_QL    = 6'b001000,
      S_QR    = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type                  state_ff, state_in;
   logic [stsum_pkg::SIZE_W-1:0] size_ff;
   logic [AW-1:0]              node_ff, node_in;
   logic [RW-1:0]              l_ff, l_in;
   logic [RW-1:0]              r_ff, r_in;
   logic [VW-1:0]              acc_ff, acc_in;
   logic                       pend_ff, pend_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]              rsp_sum_ff, rsp_sum_in;

   logic [31:0]                max32;
   logic [31:0]                size_eff;
   logic [31:0]                hi_clip;
   logic                       q_empty;
   logic                       u_ok;
   logic [AW-1:0]              leaf;
   logic [RW-1:0]              l_init;
   logic [RW-1:0]              r_init;
   logic [RW-1:0]              r_dec;
   logic [RW-1:0]              r_next;
   logic [AW-1:0]              parent;
   logic [VW-1:0]              sum;
   logic                       accept;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [VW-1:0]              wr_data;
   logic [AW-1:0]              rd_addr;
   logic [VW-1:0]              rd_data;
   logic                       clear_busy;

   stsum_node_store #(
      .NODES (NODES),
      .AW    (AW)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .clear_busy (clear_busy)
   );

   assign req_bus.ready = (state_ff == S_IDLE) && !clear_busy;
   assign accept        = req_bus.valid && req_bus.ready;

   // Effective size, clipped query bounds and leaf positions.
   always_comb begin
      max32    = 32'(MAX_ELEMENTS);
      size_eff = (32'(size_ff) > max32) ? max32 : 32'(size_ff);
      hi_clip  = 32'(req_bus.range_high);
      if ((size_eff != 32'd0) && (hi_clip > (size_eff - 32'd1))) begin
         hi_clip = size_eff - 32'd1;
      end
      q_empty = (size_eff == 32'd0) || (32'(req_bus.range_low) > hi_clip);
      u_ok    = 32'(req_bus.update_index) < size_eff;
      leaf    = AW'(32'(req_bus.update_index) + max32);
      l_init  = RW'(32'(req_bus.range_low) + max32);
      r_init  = RW'(hi_clip + max32 + 32'd1);
   end

   // The one shared adder folds registered node data into the running sum.
   assign sum    = acc_ff + rd_data;
   assign parent = node_ff >> 1;
   assign r_dec  = r_ff - 1'b1;

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      acc_in       = acc_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_sum_in   = rsp_sum_ff;
      wr_en        = 1'b0;
      wr_addr      = leaf;
      wr_data      = req_bus.new_value;
      rd_addr      = node_ff ^ AW'(1);
      r_next       = r_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_bus.operation == stsum_pkg::OP_SET) begin
                  if (u_ok) begin
                     wr_en    = 1'b1;
                     acc_in   = req_bus.new_value;
                     node_in  = leaf;
                     state_in = S_UREAD;
                  end
               end else begin
                  acc_in  = '0;
                  pend_in = 1'b0;
                  l_in    = l_init;
                  r_in    = r_init;
                  state_in = q_empty ? S_OUT : S_QL;
               end
            end
         end
         S_UREAD: begin
            rd_addr  = node_ff ^ AW'(1);
            state_in = S_UADD;
         end
         S_UADD: begin
            wr_en    = 1'b1;
            wr_addr  = parent;
            wr_data  = sum;
            acc_in   = sum;
            node_in  = parent;
            state_in = (parent == AW'(1)) ? S_IDLE : S_UREAD;
         end
         S_QL: begin
            acc_in = pend_ff ? sum : acc_ff;
            if (l_ff >= r_ff) begin
               pend_in  = 1'b0;
               state_in = S_OUT;
            end else begin
               rd_addr  = l_ff[AW-1:0];
               pend_in  = l_ff[0];
               if (l_ff[0]) begin
                  l_in = l_ff + 1'b1;
               end
               state_in = S_QR;
            end
         end
         S_QR: begin
            acc_in  = pend_ff ? sum : acc_ff;
            rd_addr = r_dec[AW-1:0];
            pend_in = r_ff[0];
            if (r_ff[0]) begin
               r_next = r_dec;
            end
            l_in     = l_ff >> 1;
            r_in     = r_next >> 1;
            state_in = S_QL;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_ff      <= stsum_pkg::ARRAY_SIZE_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            size_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      node_ff    <= node_in;
      l_ff       <= l_in;
      r_ff       <= r_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.range_sum = rsp_sum_ff;

   `ST_ASSERT_SAME(a_no_accept_while_clearing, clock, reset, clear_busy, !req_bus.ready, "transaction accepted during clearing pass")
   `ST_ASSERT_SAME(a_query_bounds_ordered, clock, reset, state_ff == S_QR, l_ff <= r_ff, "query bounds crossed")
   `ST_ASSERT_SAME(a_update_below_root, clock, reset, state_ff == S_UREAD, node_ff > AW'(1), "update walk passed the root")
   `ST_ASSERT_NEXT(a_result_only_from_out, clock, reset, state_ff != S_OUT && !rsp_valid_ff, !rsp_valid_ff, "result appeared without a finished query")

endmodule
